@@ hw/rtl/slpp_pkg.sv @@
// ----------------------------------------------------------------------------
// slpp_pkg
// Shared widths and defaults for the spectral local peak picker.
// ----------------------------------------------------------------------------
package slpp_pkg;

  localparam int MAG_W   = 16;  // signed Q8.8 dB
  localparam int FRAME_W = 16;
  localparam int THR_W   = 15;

  localparam logic [THR_W-1:0] THR_RESET = 15'd2560;  // 10.0 dB

  localparam int HALF_WINDOW_DEF = 5;
  localparam int MAX_BINS_DEF    = 4096;

endpackage
// ----------------------------------------------------------------------------

@@ hw/rtl/slpp_window.sv @@
// ----------------------------------------------------------------------------
// slpp_window
// Magnitude shift line (most recent first) and saturating bin counter.
// ----------------------------------------------------------------------------
module slpp_window
  import slpp_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF,
  parameter int MAX_BINS    = MAX_BINS_DEF,
  localparam int WIN_DEPTH  = 2 * HALF_WINDOW,
  localparam int BIN_W      = $clog2(MAX_BINS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic signed [MAG_W-1:0]           cur_mag,
  input  logic                              cur_last,
  output logic [WIN_DEPTH-1:0][MAG_W-1:0]   win,
  output logic [BIN_W-1:0]                  count
);

  logic [WIN_DEPTH-1:0][MAG_W-1:0] win_r;
  logic [BIN_W-1:0]                count_r;
  logic [BIN_W-1:0]                count_nxt;

  // No reset on the shift line: entries from before reset or a last bin are never tested
  always_ff @(posedge clk) begin
    if (adv) begin
      win_r <= {win_r[WIN_DEPTH-2:0], cur_mag};
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cur_last) begin
      count_nxt = '0;
    end else if (count_r != BIN_W'(MAX_BINS - 1)) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (adv) begin
      count_r <= count_nxt;
    end
  end

  assign win   = win_r;
  assign count = count_r;

`ifndef ASSERT_OFF
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && cur_last |=> count_r == '0)
    else $error("bin counter not cleared after last bin");
`endif

endmodule
// ----------------------------------------------------------------------------

@@ hw/rtl/slpp_detect.sv @@
// ----------------------------------------------------------------------------
// slpp_detect
// Parallel local-maximum test of the centre bin against its neighbours.
// ----------------------------------------------------------------------------
module slpp_detect
  import slpp_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF,
  parameter int MAX_BINS    = MAX_BINS_DEF,
  localparam int WIN_DEPTH  = 2 * HALF_WINDOW,
  localparam int BIN_W      = $clog2(MAX_BINS)
) (
  input  logic [WIN_DEPTH-1:0][MAG_W-1:0]  win,
  input  logic [BIN_W-1:0]                 count,
  input  logic signed [MAG_W-1:0]          cur_mag,
  input  logic [THR_W-1:0]                 threshold,
  output logic                             hit,
  output logic signed [MAG_W-1:0]          cand
);

  logic [WIN_DEPTH-1:0] below;
  logic                 full;
  logic                 above_thr;

  assign cand = $signed(win[HALF_WINDOW-1]);

  always_comb begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (k == HALF_WINDOW - 1) begin
        below[k] = 1'b1;
      end else begin
        below[k] = $signed(win[k]) < cand;
      end
    end
  end

  assign full      = 32'(count) >= 32'(WIN_DEPTH);
  assign above_thr = cand > $signed({{(MAG_W-THR_W){1'b0}}, threshold});
  assign hit       = full && above_thr && (cur_mag < cand) && (&below);

endmodule
// ----------------------------------------------------------------------------

@@ hw/rtl/spectral_local_peak_picker.sv @@
// Path: an input transaction is held in the input reg, then its result in the result reg.
// Throughput: one bin per cycle; the single compare stage between the input
//   and result registers sets the rate, stalled only by out_stall.
// Reset (rst_n, synchronous, active low): clears valids and bin counter,
//   threshold returns to 10.0 dB; the magnitude shift line is not reset.
// ----------------------------------------------------------------------------
// spectral_local_peak_picker
// Streams spectrum bins and reports strict local maxima above a threshold.
// ----------------------------------------------------------------------------
module spectral_local_peak_picker
  import slpp_pkg::*;
#(
  parameter int HALF_WINDOW = HALF_WINDOW_DEF,
  parameter int MAX_BINS    = MAX_BINS_DEF,
  localparam int WIN_DEPTH  = 2 * HALF_WINDOW,
  localparam int BIN_W      = $clog2(MAX_BINS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [THR_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [MAG_W-1:0]    in_magnitude_db,
  input  logic [FRAME_W-1:0]         in_frame_number,
  input  logic                       in_last_bin,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [FRAME_W-1:0]         out_peak_frame,
  output logic [BIN_W-1:0]           out_peak_bin,
  output logic signed [MAG_W-1:0]    out_peak_magnitude
);

  logic [THR_W-1:0]          thr_r;
  logic                      in_valid_r;
  logic signed [MAG_W-1:0]   mag_r;
  logic [FRAME_W-1:0]        frame_r;
  logic                      last_r;
  logic                      out_valid_r;
  logic [FRAME_W-1:0]        peak_frame_r;
  logic [BIN_W-1:0]          peak_bin_r;
  logic signed [MAG_W-1:0]   peak_mag_r;

  logic                            proceed;
  logic                            in_take;
  logic [WIN_DEPTH-1:0][MAG_W-1:0] win;
  logic [BIN_W-1:0]                count;
  logic                            hit;
  logic signed [MAG_W-1:0]         cand;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // Held item moves on once the result register is free or being drained
  assign proceed  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !proceed;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (proceed) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mag_r   <= in_magnitude_db;
      frame_r <= in_frame_number;
      last_r  <= in_last_bin;
    end
  end

  slpp_window #(
    .HALF_WINDOW (HALF_WINDOW),
    .MAX_BINS    (MAX_BINS)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (proceed),
    .cur_mag  (mag_r),
    .cur_last (last_r),
    .win      (win),
    .count    (count)
  );

  slpp_detect #(
    .HALF_WINDOW (HALF_WINDOW),
    .MAX_BINS    (MAX_BINS)
  ) u_detect (
    .win       (win),
    .count     (count),
    .cur_mag   (mag_r),
    .threshold (thr_r),
    .hit       (hit),
    .cand      (cand)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed) begin
      out_valid_r <= hit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && hit) begin
      peak_frame_r <= frame_r;
      peak_bin_r   <= count - BIN_W'(HALF_WINDOW);
      peak_mag_r   <= cand;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_peak_frame     = peak_frame_r;
  assign out_peak_bin       = peak_bin_r;
  assign out_peak_magnitude = peak_mag_r;

`ifndef ASSERT_OFF
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_hit_reported: assert property (@(posedge clk) disable iff (!rst_n)
    proceed && hit |=> out_valid_r)
    else $error("detected peak not presented");

  a_bin_off_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> 32'(peak_bin_r) >= 32'(HALF_WINDOW))
    else $error("peak reported inside frame edge");
`endif

endmodule
// ----------------------------------------------------------------------------

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams spectrum bins into the peak picker and checks each reported peak
// against a local predictor, across threshold settings and long frames.
// ----------------------------------------------------------------------------
module tb
  import slpp_pkg::*;
();

  localparam int HALF_W     = HALF_WINDOW_DEF;
  localparam int WIN_DEPTH  = 2 * HALF_W;
  localparam int BIN_W      = $clog2(MAX_BINS_DEF);
  localparam int BIN_LAST   = MAX_BINS_DEF - 1;
  localparam int SETTLE     = 8;     // margin past the input and result registers
  localparam int HOLD_LEN   = 300;
  localparam int QUIET_MAX  = 3000;
  localparam int N_PHASES   = 6;

  typedef struct packed {
    logic signed [MAG_W-1:0] mag;
    logic [FRAME_W-1:0]      frame;
    logic                    last;
  } bin_t;

  typedef struct packed {
    logic [FRAME_W-1:0]      frame;
    logic [BIN_W-1:0]        bin;
    logic signed [MAG_W-1:0] mag;
  } peak_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [THR_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [MAG_W-1:0] in_magnitude_db = '0;
  logic [FRAME_W-1:0]      in_frame_number = '0;
  logic                    in_last_bin = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [FRAME_W-1:0]      out_peak_frame;
  logic [BIN_W-1:0]        out_peak_bin;
  logic signed [MAG_W-1:0] out_peak_magnitude;

  // predictor state
  logic signed [MAG_W-1:0] mag_hist [WIN_DEPTH] = '{default: '0};
  logic [BIN_W-1:0]        bin_idx = '0;
  logic [THR_W-1:0]        thr_model = THR_RESET;

  bin_t  bin_feed [$];
  peak_t peaks_due [$];
  bin_t  cur_bin;
  peak_t want;

  int    src_idle_pct = 28;
  int    snk_idle_pct = 28;
  bit    hold_go = 1'b0;
  bit    hold_done = 1'b0;
  int    hold_left = 0;
  int    quiet_cycles = 0;
  int    err_count = 0;
  int    bins_sent = 0;
  int    peaks_seen = 0;
  int    prev_mag = 0;
  logic [FRAME_W-1:0] frame_no = '0;

  spectral_local_peak_picker u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_magnitude_db    (in_magnitude_db),
    .in_frame_number    (in_frame_number),
    .in_last_bin        (in_last_bin),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_peak_frame     (out_peak_frame),
    .out_peak_bin       (out_peak_bin),
    .out_peak_magnitude (out_peak_magnitude)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Advance the predictor by one accepted bin; queue a peak if one is found.
  task automatic track_bin(input bin_t b);
    peak_t pk;
    bit    hit;
    logic signed [MAG_W-1:0] cand;
    hit = 1'b0;
    cand = mag_hist[HALF_W-1];
    if (bin_idx >= WIN_DEPTH) begin
      hit = (cand > $signed({1'b0, thr_model})) && (b.mag < cand);
      for (int k = 0; k < WIN_DEPTH; k++)
        if (k != HALF_W - 1 && mag_hist[k] >= cand) hit = 1'b0;
      if (hit) begin
        pk.frame = b.frame;
        pk.bin   = bin_idx - BIN_W'(HALF_W);
        pk.mag   = cand;
        peaks_due.push_back(pk);
      end
    end
    for (int k = WIN_DEPTH - 1; k > 0; k--) mag_hist[k] = mag_hist[k-1];
    mag_hist[0] = b.mag;
    if (b.last) bin_idx = '0;
    else if (bin_idx != BIN_W'(BIN_LAST)) bin_idx++;
  endtask

  function automatic logic signed [MAG_W-1:0] rand_mag();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 58)      v = int'($urandom_range(0, 4000)) - 2000;
    else if (r < 78) v = int'(thr_model) + int'($urandom_range(0, 6000)) - 1000;
    else if (r < 83) v = int'(thr_model);
    else if (r < 88) v = int'(thr_model) + 1;
    else if (r < 94) v = prev_mag;  // plateau: equal neighbours
    else             v = int'($urandom_range(0, 65535)) - 32768;
    if (v > 32767) v = 32767;
    prev_mag = v;
    return v[MAG_W-1:0];
  endfunction

  function automatic void feed(input int mag, input logic [FRAME_W-1:0] frame,
                               input bit last);
    bin_t b;
    b.mag   = mag[MAG_W-1:0];
    b.frame = frame;
    b.last  = last;
    bin_feed.push_back(b);
  endfunction

  // Mostly whole frames with random content; some short, some unterminated
  // with the frame number changing mid-stream.
  task automatic queue_frames(input int n_bins);
    int left;
    int len;
    int r;
    bit broken;
    left = n_bins;
    while (left > 0) begin
      r = $urandom_range(0, 99);
      if (r < 8)       len = $urandom_range(1, 10);
      else if (r < 11) len = $urandom_range(60, 200);
      else             len = $urandom_range(11, 40);
      if ($urandom_range(0, 9) == 0) frame_no = FRAME_W'($urandom_range(0, 65535));
      else frame_no++;
      broken = ($urandom_range(0, 99) < 12);
      for (int i = 0; i < len; i++) begin
        if (broken && i == len / 2) frame_no++;
        feed(rand_mag(), frame_no, !broken && i == len - 1);
      end
      left -= len;
    end
  endtask

  task automatic set_threshold(input logic [THR_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    thr_model = v;
  endtask

  // Let the sender run dry and every due peak arrive, then settle.
  task automatic drain();
    do @(posedge clk);
    while (bin_feed.size() != 0 || in_valid || peaks_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sender: one transaction per accepted bin; payload held while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_bin(cur_bin);
        bins_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (bin_feed.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_bin = bin_feed.pop_front();
          in_magnitude_db <= cur_bin.mag;
          in_frame_number <= cur_bin.frame;
          in_last_bin     <= cur_bin.last;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result transaction, drive out_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (peaks_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected peak: expected none, got frame=%0d bin=%0d mag=%0d",
                   $time, out_peak_frame, out_peak_bin, out_peak_magnitude);
        end else begin
          want = peaks_due.pop_front();
          if (out_peak_frame !== want.frame || out_peak_bin !== want.bin ||
              out_peak_magnitude !== want.mag) begin
            err_count++;
            $display("%0t: peak mismatch: exp f=%0d b=%0d m=%0d, got f=%0d b=%0d m=%0d",
                     $time, want.frame, want.bin, want.mag,
                     out_peak_frame, out_peak_bin, out_peak_magnitude);
          end else begin
            peaks_seen++;
          end
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [THR_W-1:0] thr_plan [N_PHASES];
    int               n_plan [N_PHASES];
    thr_plan = '{15'd0, 15'd32767, THR_RESET, 15'd0, 15'd1, 15'd0};
    n_plan   = '{200, 100, 200, 200, 200, 200};
    thr_plan[3] = THR_W'($urandom_range(0, 6000));
    thr_plan[5] = THR_W'($urandom_range(0, 32767));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, threshold at reset value. Full-scale peak mid-frame.
    for (int i = 0; i < 11; i++) feed(i == 5 ? 32767 : -32768, 16'd100, i == 10);
    // Full-scale edge bins, frame number change without last_bin.
    for (int i = 0; i < 14; i++)
      feed((i == 0 || i == 13) ? 32767 : (i == 7 ? 20000 : 0),
           i < 7 ? 16'h1234 : 16'hFFFF, i == 13);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      set_threshold(thr_plan[p]);
      src_idle_pct = (p == 2) ? 0 : 28;
      snk_idle_pct = (p == 2) ? 0 : 28;
      if (p == 0) hold_go = 1'b1;  // receiver holds off while bins keep coming
      queue_frames(n_plan[p]);
      drain();
    end

    $display("Run: %0d bins sent, %0d peaks matched, %0d mismatches", bins_sent,
             peaks_seen, err_count);
    $display("Run: thresholds 0..32767, frame edges, unterminated frames, long hold-off");
    if (err_count == 0 && peaks_due.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
